### rtl/ssm_pkg.sv
// shared widths, register indices and configuration type for the shadow split block
package ssm_pkg;

    // field widths
    localparam int C_W = 24;
    localparam int L_W = 16;
    localparam int R_W = 23;
    localparam int S_W = 24;

    // split walk
    localparam int NUM_SPLITS = 4;
    localparam int MAX_SPLITS = 4;
    localparam int MASK_W = MAX_SPLITS + 1;
    localparam int LAST_BIT = (NUM_SPLITS < MAX_SPLITS) ? NUM_SPLITS : MAX_SPLITS;

    // datapath widths
    localparam int FRAC_L = 14;
    localparam int PROD_W = C_W + L_W;
    localparam int ACC_W = PROD_W + 2;
    localparam int DOT_W = ACC_W - FRAC_L;
    localparam int PROJ_W = L_W + DOT_W;
    localparam int T_W = PROJ_W - FRAC_L;
    localparam int P_W = T_W + 1;
    localparam int ABS_W = P_W;
    localparam int SQR_W = 2 * ABS_W;
    localparam int SQ_W = SQR_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int RW_W = R_W + 1;
    localparam int DMAX_W = ROOT_W + 1;
    localparam int RW_SHIFT = 10;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_3 = 3'd6;

    localparam logic signed [L_W-1:0] LIGHT_X_RESET = 16'sd0;
    localparam logic signed [L_W-1:0] LIGHT_Y_RESET = -16'sd16384;
    localparam logic signed [L_W-1:0] LIGHT_Z_RESET = 16'sd0;

    typedef struct packed {
        logic signed [L_W-1:0]                 light_x;
        logic signed [L_W-1:0]                 light_y;
        logic signed [L_W-1:0]                 light_z;
        logic [MAX_SPLITS-1:0][S_W-1:0]        split_dist;
    } ssm_cfg_t;

endpackage

### rtl/ssm_if.sv
// channel interfaces: sphere input, split mask output, configuration writes
interface ssm_sphere_if;
    import ssm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [C_W-1:0] center_x;
    logic signed [C_W-1:0] center_y;
    logic signed [C_W-1:0] center_z;
    logic [R_W-1:0]        sphere_radius;

    modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
    modport sink (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface ssm_mask_if;
    import ssm_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] split_mask;

    modport source (output valid, split_mask, input ready);
    modport sink (input valid, split_mask, output ready);
endinterface

interface ssm_cfg_if;
    import ssm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/shadow_split_membership_top.sv
// top level of the shadow split membership block: configuration registers and pipeline
//
// channels
//   cfg     configuration writes; index selects light_x, light_y, light_z (q1.14) or
//           split_dist_0..3 (q.8); always ready, unknown indices are dropped
//   sphere  one bounding sphere per transaction: centre relative to camera and radius
//   result  one five-bit split mask per sphere, in arrival order
// throughput: one sphere per cycle sustained, set by the single shared stall of the
//   pipeline; ready on sphere drops only while a mask waits in the output register
//   and the receiver holds ready low
// pipeline: 6 stages of projection and squaring, 32 stages of square root (one root
//   bit each), 2 stages of split walk
// reset: rst_n is asynchronous and active low; it empties the pipeline and loads the
//   light with straight down (y = -1.0) and all split distances with zero
// stall: when result is valid and not taken, every stage holds its contents and the
//   sphere channel stops taking transactions; nothing is lost or repeated
// configuration is expected only while the pipeline is empty
module shadow_split_membership_top (
    input  logic       clk,
    input  logic       rst_n,
    ssm_cfg_if.sink    cfg,
    ssm_sphere_if.sink sphere,
    ssm_mask_if.source result
);
    import ssm_pkg::*;

    // configuration registers
    logic signed [L_W-1:0] light_x_reg;
    logic signed [L_W-1:0] light_y_reg;
    logic signed [L_W-1:0] light_z_reg;
    logic [S_W-1:0]        split_reg [MAX_SPLITS];
    logic                  cfg_we;
    ssm_cfg_t              cfg_s;

    // pipeline control: the whole pipe moves together
    logic                  advance;

    // links between the sections
    logic                  proj_valid;
    logic [SQ_W-1:0]       proj_sq;
    logic [RW_W-1:0]       proj_rw;
    logic                  root_valid;
    logic [ROOT_W-1:0]     root_val;
    logic [RW_W-1:0]       root_rw;
    logic                  sel_valid;
    logic [MASK_W-1:0]     sel_mask;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // register writes, light keeps the low 16 bits of the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= LIGHT_X_RESET;
            light_y_reg <= LIGHT_Y_RESET;
            light_z_reg <= LIGHT_Z_RESET;
            for (int i = 0; i < MAX_SPLITS; i++)
            begin
                split_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg.index) inside
                REG_LIGHT_X: light_x_reg <= cfg.data[L_W-1:0];
                REG_LIGHT_Y: light_y_reg <= cfg.data[L_W-1:0];
                REG_LIGHT_Z: light_z_reg <= cfg.data[L_W-1:0];
                REG_SPLIT_0: split_reg[0] <= cfg.data[S_W-1:0];
                REG_SPLIT_1: split_reg[1] <= cfg.data[S_W-1:0];
                REG_SPLIT_2: split_reg[2] <= cfg.data[S_W-1:0];
                REG_SPLIT_3: split_reg[3] <= cfg.data[S_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg_s.light_x = light_x_reg;
        cfg_s.light_y = light_y_reg;
        cfg_s.light_z = light_z_reg;
        for (int i = 0; i < MAX_SPLITS; i++)
        begin
            cfg_s.split_dist[i] = split_reg[i];
        end
    end

    // output register empty or being drained
    assign advance      = !sel_valid || result.ready;
    assign sphere.ready = advance;

    // projection removal and squared distance
    ssm_proj u_proj (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .in_valid      (sphere.valid),
        .center_x      (sphere.center_x),
        .center_y      (sphere.center_y),
        .center_z      (sphere.center_z),
        .sphere_radius (sphere.sphere_radius),
        .cfg           (cfg_s),
        .out_valid     (proj_valid),
        .sq            (proj_sq),
        .rw            (proj_rw)
    );

    // distance to the light axis
    ssm_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (proj_valid),
        .sq        (proj_sq),
        .rw_in     (proj_rw),
        .out_valid (root_valid),
        .root      (root_val),
        .rw_out    (root_rw)
    );

    // split walk and output register
    ssm_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (root_valid),
        .root       (root_val),
        .rw         (root_rw),
        .cfg        (cfg_s),
        .out_valid  (sel_valid),
        .split_mask (sel_mask)
    );

    assign result.valid      = sel_valid;
    assign result.split_mask = sel_mask;

`ifndef SYNTHESIS
    // the split holding the sphere's near edge is always reported
    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.split_mask != '0))
        else $error("empty split mask");
`endif

endmodule

### rtl/ssm_proj.sv
// six-stage front end: light projection removal and squared distance to the light axis
module ssm_proj (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ssm_pkg::C_W-1:0] center_x,
    input  logic signed [ssm_pkg::C_W-1:0] center_y,
    input  logic signed [ssm_pkg::C_W-1:0] center_z,
    input  logic [ssm_pkg::R_W-1:0]       sphere_radius,
    input  ssm_pkg::ssm_cfg_t             cfg,
    output logic                          out_valid,
    output logic [ssm_pkg::SQ_W-1:0]      sq,
    output logic [ssm_pkg::RW_W-1:0]      rw
);
    import ssm_pkg::*;

    localparam int STAGES = 6;

    logic                   v_reg [STAGES];
    logic signed [L_W-1:0]  light [3];
    logic signed [C_W-1:0]  cin [3];

    // stage 1
    logic signed [C_W-1:0]    c1_reg [3];
    logic signed [PROD_W-1:0] prod1_reg [3];
    logic signed [PROD_W-1:0] prod1_next [3];
    logic [RW_W-1:0]          rw1_reg;
    logic [RW_W-1:0]          rw1_next;
    // stage 2
    logic signed [C_W-1:0]    c2_reg [3];
    logic signed [DOT_W-1:0]  dot2_reg;
    logic signed [DOT_W-1:0]  dot2_next;
    logic signed [ACC_W-1:0]  acc;
    logic [RW_W-1:0]          rw2_reg;
    // stage 3
    logic signed [C_W-1:0]    c3_reg [3];
    logic signed [PROJ_W-1:0] proj3_reg [3];
    logic signed [PROJ_W-1:0] proj3_next [3];
    logic [RW_W-1:0]          rw3_reg;
    // stage 4
    logic [ABS_W-1:0]         abs4_reg [3];
    logic [ABS_W-1:0]         abs4_next [3];
    logic [RW_W-1:0]          rw4_reg;
    // stage 5
    logic [SQR_W-1:0]         sqr5_reg [3];
    logic [SQR_W-1:0]         sqr5_next [3];
    logic [RW_W-1:0]          rw5_reg;
    // stage 6
    logic [SQ_W-1:0]          sq6_reg;
    logic [SQ_W-1:0]          sq6_next;
    logic [RW_W-1:0]          rw6_reg;

    always_comb
    begin
        light[0] = cfg.light_x;
        light[1] = cfg.light_y;
        light[2] = cfg.light_z;
        cin[0]   = center_x;
        cin[1]   = center_y;
        cin[2]   = center_z;
    end

    // widened radius and per-axis products
    always_comb
    begin
        rw1_next = RW_W'(sphere_radius) + RW_W'(sphere_radius >> RW_SHIFT) + RW_W'(1);
        for (int i = 0; i < 3; i++)
        begin
            prod1_next[i] = PROD_W'(cin[i]) * PROD_W'(light[i]);
        end
    end

    // dot product, floored back to q.8
    always_comb
    begin
        acc = ACC_W'(prod1_reg[0]) + ACC_W'(prod1_reg[1]) + ACC_W'(prod1_reg[2]);
        dot2_next = acc[ACC_W-1:FRAC_L];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            proj3_next[i] = PROJ_W'(light[i]) * PROJ_W'(dot2_reg);
        end
    end

    // offset from the light axis and the magnitude of each of its components
    always_comb
    begin
        logic signed [T_W-1:0] t;
        logic signed [P_W-1:0] p;
        for (int i = 0; i < 3; i++)
        begin
            t = proj3_reg[i][PROJ_W-1:FRAC_L];
            p = P_W'(c3_reg[i]) - P_W'(t);
            abs4_next[i] = p[P_W-1] ? ABS_W'(-p) : ABS_W'(p);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqr5_next[i] = SQR_W'(abs4_reg[i]) * SQR_W'(abs4_reg[i]);
        end
    end

    always_comb
    begin
        sq6_next = SQ_W'(sqr5_reg[0]) + SQ_W'(sqr5_reg[1]) + SQ_W'(sqr5_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c1_reg[i]    <= cin[i];
                prod1_reg[i] <= prod1_next[i];
                c2_reg[i]    <= c1_reg[i];
                c3_reg[i]    <= c2_reg[i];
                proj3_reg[i] <= proj3_next[i];
                abs4_reg[i]  <= abs4_next[i];
                sqr5_reg[i]  <= sqr5_next[i];
            end
            rw1_reg  <= rw1_next;
            dot2_reg <= dot2_next;
            rw2_reg  <= rw1_reg;
            rw3_reg  <= rw2_reg;
            rw4_reg  <= rw3_reg;
            rw5_reg  <= rw4_reg;
            sq6_reg  <= sq6_next;
            rw6_reg  <= rw5_reg;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign sq        = sq6_reg;
    assign rw        = rw6_reg;

endmodule

### rtl/ssm_isqrt.sv
// pipelined floored square root, one result bit per stage, widened radius carried alongside
module ssm_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [ssm_pkg::SQ_W-1:0]   sq,
    input  logic [ssm_pkg::RW_W-1:0]   rw_in,
    output logic                       out_valid,
    output logic [ssm_pkg::ROOT_W-1:0] root,
    output logic [ssm_pkg::RW_W-1:0]   rw_out
);
    import ssm_pkg::*;

    logic                v_reg   [ROOT_W];
    logic [SQ_W-1:0]     rem_reg [ROOT_W];
    logic [ROOT_W-1:0]   q_reg   [ROOT_W];
    logic [RW_W-1:0]     rw_reg  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_step
        localparam int J = ROOT_W - 1 - s;

        logic              v_in;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] q_in;
        logic [RW_W-1:0]   rw_stage_in;
        logic [SQ_W:0]     trial;
        logic              fits;

        if (s == 0)
        begin : g_first
            assign v_in        = in_valid;
            assign rem_in      = sq;
            assign q_in        = '0;
            assign rw_stage_in = rw_in;
        end
        else
        begin : g_next
            assign v_in        = v_reg[s-1];
            assign rem_in      = rem_reg[s-1];
            assign q_in        = q_reg[s-1];
            assign rw_stage_in = rw_reg[s-1];
        end

        // (q + 2^j)^2 - q^2 against the running remainder
        assign trial = ((SQ_W+1)'(q_in) << (J + 1)) + ((SQ_W+1)'(1) << (2 * J));
        assign fits  = (trial <= {1'b0, rem_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= fits ? (rem_in - trial[SQ_W-1:0]) : rem_in;
                q_reg[s]   <= fits ? (q_in | (ROOT_W'(1) << J)) : q_in;
                rw_reg[s]  <= rw_stage_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = q_reg[ROOT_W-1];
    assign rw_out    = rw_reg[ROOT_W-1];

`ifndef SYNTHESIS
    // floored root leaves a remainder no larger than twice the root
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ROOT_W-1] |-> ((SQ_W+1)'(rem_reg[ROOT_W-1])
                             <= ((SQ_W+1)'(q_reg[ROOT_W-1]) << 1)))
        else $error("square root remainder out of range");
`endif

endmodule

### rtl/ssm_select.sv
// distance range and split walk, ending in the output register
module ssm_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ssm_pkg::ROOT_W-1:0]  root,
    input  logic [ssm_pkg::RW_W-1:0]    rw,
    input  ssm_pkg::ssm_cfg_t           cfg,
    output logic                        out_valid,
    output logic [ssm_pkg::MASK_W-1:0]  split_mask
);
    import ssm_pkg::*;

    logic                dv_reg;
    logic [ROOT_W-1:0]   dmin_reg;
    logic [ROOT_W-1:0]   dmin_next;
    logic [DMAX_W-1:0]   dmax_reg;
    logic [DMAX_W-1:0]   dmax_next;
    logic                mv_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [MASK_W-1:0]   mask_next;

    always_comb
    begin
        dmin_next = (root > ROOT_W'(rw)) ? (root - ROOT_W'(rw)) : '0;
        dmax_next = DMAX_W'(root) + DMAX_W'(rw);
    end

    // walk splits in index order, stop at the first one past the far edge
    always_comb
    begin
        logic stopped;
        stopped   = 1'b0;
        mask_next = '0;
        for (int i = 0; i < NUM_SPLITS; i++)
        begin
            if (!stopped)
            begin
                if (DMAX_W'(dmin_reg) < DMAX_W'(cfg.split_dist[i]))
                begin
                    mask_next[i] = 1'b1;
                end
                if (dmax_reg <= DMAX_W'(cfg.split_dist[i]))
                begin
                    stopped = 1'b1;
                end
            end
        end
        if (!stopped)
        begin
            mask_next[LAST_BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= 1'b0;
            mv_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg <= in_valid;
            mv_reg <= dv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmin_reg <= dmin_next;
            dmax_reg <= dmax_next;
            mask_reg <= mask_next;
        end
    end

    assign out_valid  = mv_reg;
    assign split_mask = mask_reg;

`ifndef SYNTHESIS
    // widened radius is at least one lsb, so the range never collapses
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (DMAX_W'(dmin_reg) < dmax_reg))
        else $error("distance range empty");
`endif

endmodule

### tb/sv/shadow_split_membership_top_tb.sv
// testbench for the shadow split membership block: directed and random spheres, masks checked
module shadow_split_membership_top_tb;
    import ssm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // pipeline depth from sphere transaction to mask, used only for the final quiet period
    localparam int PIPE_LATENCY    = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int LONG_HOLD       = 300;

    // index with no register behind it, writes to it must leave everything alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [C_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [C_W-1:0] C_MIN = 24'sh800000;
    localparam logic [R_W-1:0]        R_MAX = 23'h7FFFFF;
    localparam logic [S_W-1:0] SPLIT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic signed [C_W-1:0] center_x;
        logic signed [C_W-1:0] center_y;
        logic signed [C_W-1:0] center_z;
        logic [R_W-1:0]        sphere_radius;
    } sphere_item_t;

    logic clk;
    logic rst_n;

    ssm_cfg_if    cfg_ch ();
    ssm_sphere_if sphere_ch ();
    ssm_mask_if   mask_ch ();

    shadow_split_membership_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sphere (sphere_ch),
        .result (mask_ch)
    );

    // spheres waiting for the driver, and masks waiting for the block
    sphere_item_t           pending_spheres[$];
    logic [MASK_W-1:0]      expected_masks[$];

    // our copy of the register file, updated on each accepted write
    ssm_cfg_t               shadow_cfg;

    int                     spheres_queued   = 0;
    int                     spheres_accepted = 0;
    int                     mask_errors      = 0;
    logic                   sphere_fire      = 1'b0;
    logic [MASK_W-1:0]      exp_mask;

    // idling controls, written only by the sequencing block
    bit                     tx_idle_en   = 1'b1;
    bit                     rx_idle_en   = 1'b1;
    bit                     hold_request = 1'b0;

    // driver and receiver private state
    int                     burst_left   = 0;
    int                     gap_left     = 0;
    int                     hold_left    = 0;
    bit                     hold_done    = 1'b0;
    int                     pattern_left = 0;
    logic [15:0]            stall_pattern = 16'hFFFF;
    sphere_item_t           drive_item;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: distance of the centre from the light axis, then the split walk
    // ------------------------------------------------------------------
    function automatic logic [MASK_W-1:0] predict_split_mask(
        input logic signed [C_W-1:0] cx,
        input logic signed [C_W-1:0] cy,
        input logic signed [C_W-1:0] cz,
        input logic [R_W-1:0]        rad,
        input ssm_cfg_t              c
    );
        longint            cv[3];
        longint            lv[3];
        longint            dot;
        longint            offset;
        longint            mag;
        logic [63:0]       sq;
        logic [63:0]       rem;
        logic [63:0]       root;
        logic [63:0]       probe;
        logic [63:0]       widened;
        logic [63:0]       dmin;
        logic [63:0]       dmax;
        logic [MASK_W-1:0] mask;
        bit                stopped;
        cv[0] = cx;
        cv[1] = cy;
        cv[2] = cz;
        lv[0] = c.light_x;
        lv[1] = c.light_y;
        lv[2] = c.light_z;

        // radius grows by about a thousandth plus one lsb
        widened = 64'(rad) + 64'(rad >> RW_SHIFT) + 64'd1;

        // component along the light, floored back to q.8
        dot = (cv[0] * lv[0] + cv[1] * lv[1] + cv[2] * lv[2]) >>> FRAC_L;

        // squared length of what is left once that component is removed
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            offset = cv[i] - ((lv[i] * dot) >>> FRAC_L);
            mag    = (offset < 0) ? -offset : offset;
            sq     = sq + 64'(mag * mag);
        end

        // exact floored square root, two bits of the radicand per step
        rem   = sq;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end

        dmin = (root > widened) ? root - widened : 64'd0;
        dmax = root + widened;

        // walk the splits in index order, whether or not they ascend
        mask    = '0;
        stopped = 1'b0;
        for (int i = 0; i < NUM_SPLITS && !stopped; i++)
        begin
            if (dmin < 64'(c.split_dist[i]))
                mask[i] = 1'b1;
            if (dmax <= 64'(c.split_dist[i]))
                stopped = 1'b1;
        end
        if (!stopped)
            mask[LAST_BIT] = 1'b1;
        return mask;
    endfunction

    // ------------------------------------------------------------------
    // random settings: unit lights, the odd raw light, splits at a chosen scale
    // ------------------------------------------------------------------
    function automatic ssm_cfg_t random_config(input int scale);
        ssm_cfg_t               c;
        real                    fx;
        real                    fy;
        real                    fz;
        real                    norm;
        int unsigned            sd[$];
        int unsigned            top;
        logic signed [L_W-1:0]  unit;
        c    = '0;
        unit = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
        case ($urandom_range(0, 3))
            0:
            begin
                // straight along one axis
                case ($urandom_range(0, 2))
                    0:       c.light_x = unit;
                    1:       c.light_y = unit;
                    default: c.light_z = unit;
                endcase
            end
            3:
            begin
                // raw register contents, not of unit length
                c.light_x = L_W'($urandom);
                c.light_y = L_W'($urandom);
                c.light_z = L_W'($urandom);
            end
            default:
            begin
                fx   = real'($urandom_range(0, 2000)) - 1000.0;
                fy   = real'($urandom_range(0, 2000)) - 1000.0;
                fz   = real'($urandom_range(0, 2000)) - 1000.0;
                norm = $sqrt(fx * fx + fy * fy + fz * fz);
                if (norm == 0.0)
                    norm = 1.0;
                c.light_x = L_W'($rtoi(fx / norm * 16384.0));
                c.light_y = L_W'($rtoi(fy / norm * 16384.0));
                c.light_z = L_W'($rtoi(fz / norm * 16384.0));
            end
        endcase

        top = (scale <= 1) ? 32'hFFFFFF : (32'd1 << (25 - scale)) - 32'd1;
        for (int i = 0; i < MAX_SPLITS; i++)
        begin
            case ($urandom_range(0, 15))
                0:       sd.push_back(0);
                1:       sd.push_back(32'hFFFFFF);
                default: sd.push_back($urandom_range(0, top));
            endcase
        end
        // mostly ascending, now and then left unsorted or with a repeated boundary
        if ($urandom_range(0, 4) != 0)
            sd.sort();
        if ($urandom_range(0, 5) == 0)
            sd[2] = sd[1];
        for (int i = 0; i < MAX_SPLITS; i++)
            c.split_dist[i] = S_W'(sd[i]);
        return c;
    endfunction

    // spheres sized to the same scale as the splits, with some full-range noise
    function automatic sphere_item_t random_sphere(input int scale);
        sphere_item_t s;
        int           sh;
        if ($urandom_range(0, 9) == 0)
        begin
            s.center_x      = C_W'($urandom);
            s.center_y      = C_W'($urandom);
            s.center_z      = C_W'($urandom);
            s.sphere_radius = R_W'($urandom);
            return s;
        end
        sh = scale + $urandom_range(0, 4) - 2;
        if (sh < 0)
            sh = 0;
        if (sh > 23)
            sh = 23;
        s.center_x      = $signed(C_W'($urandom)) >>> sh;
        s.center_y      = $signed(C_W'($urandom)) >>> sh;
        s.center_z      = $signed(C_W'($urandom)) >>> sh;
        s.sphere_radius = R_W'($urandom) >> $urandom_range(sh, 23);
        if ($urandom_range(0, 7) == 0)
            s.center_y = '0;
        if ($urandom_range(0, 11) == 0)
            s.sphere_radius = '0;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // configuration writes, only ever issued while the pipeline is empty
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        // light registers keep the low sixteen bits only
        case (idx)
            REG_LIGHT_X: shadow_cfg.light_x       = val[L_W-1:0];
            REG_LIGHT_Y: shadow_cfg.light_y       = val[L_W-1:0];
            REG_LIGHT_Z: shadow_cfg.light_z       = val[L_W-1:0];
            REG_SPLIT_0: shadow_cfg.split_dist[0] = val[S_W-1:0];
            REG_SPLIT_1: shadow_cfg.split_dist[1] = val[S_W-1:0];
            REG_SPLIT_2: shadow_cfg.split_dist[2] = val[S_W-1:0];
            REG_SPLIT_3: shadow_cfg.split_dist[3] = val[S_W-1:0];
            default: ;
        endcase
    endtask

    // every register in turn, junk in the unused upper bits, sometimes a stray index
    task automatic apply_config(input ssm_cfg_t c);
        write_reg(REG_LIGHT_X, {8'($urandom), c.light_x});
        write_reg(REG_LIGHT_Y, {8'($urandom), c.light_y});
        write_reg(REG_LIGHT_Z, {8'($urandom), c.light_z});
        write_reg(REG_SPLIT_0, c.split_dist[0]);
        write_reg(REG_SPLIT_1, c.split_dist[1]);
        write_reg(REG_SPLIT_2, c.split_dist[2]);
        write_reg(REG_SPLIT_3, c.split_dist[3]);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        // give the driver a clean edge before new spheres appear
        @(posedge clk);
    endtask

    task automatic queue_sphere(
        input logic signed [C_W-1:0] cx,
        input logic signed [C_W-1:0] cy,
        input logic signed [C_W-1:0] cz,
        input logic [R_W-1:0]        rad
    );
        sphere_item_t s;
        s.center_x      = cx;
        s.center_y      = cy;
        s.center_z      = cz;
        s.sphere_radius = rad;
        pending_spheres.push_back(s);
        spheres_queued++;
    endtask

    // quiet point: everything handed over has gone through and come back
    task automatic wait_drained();
        @(negedge clk);
        while (spheres_accepted != spheres_queued || expected_masks.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // sphere driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sphere_ch.valid <= 1'b0;
        end
        else if (!sphere_ch.valid || sphere_fire)
        begin
            // the slot is free: either idle or the last transaction went through
            if (gap_left > 0)
            begin
                gap_left--;
                sphere_ch.valid <= 1'b0;
            end
            else if (pending_spheres.size() != 0)
            begin
                drive_item = pending_spheres.pop_front();
                sphere_ch.center_x      <= drive_item.center_x;
                sphere_ch.center_y      <= drive_item.center_y;
                sphere_ch.center_z      <= drive_item.center_z;
                sphere_ch.sphere_radius <= drive_item.sphere_radius;
                sphere_ch.valid         <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 31);
                    if (!tx_idle_en || $urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 8);
                end
            end
            else
            begin
                sphere_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // mask receiver: rotating stall pattern, with long hold-offs now and then
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            mask_ch.ready <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            // long enough for the whole pipeline to back up into the sphere channel
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            mask_ch.ready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 2999) == 0)
        begin
            hold_left = $urandom_range(60, 250);
            mask_ch.ready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(16, 128);
                if (rx_idle_en && $urandom_range(0, 3) != 0)
                    stall_pattern = 16'($urandom);
                else
                    stall_pattern = 16'hFFFF;
            end
            pattern_left--;
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            mask_ch.ready <= stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each sphere transaction, check on each mask transaction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sphere_fire <= rst_n && sphere_ch.valid && sphere_ch.ready;
        if (rst_n && sphere_ch.valid && sphere_ch.ready)
        begin
            expected_masks.push_back(predict_split_mask(sphere_ch.center_x,
                sphere_ch.center_y, sphere_ch.center_z, sphere_ch.sphere_radius,
                shadow_cfg));
            spheres_accepted++;
        end
        if (rst_n && mask_ch.valid && mask_ch.ready)
        begin
            if (expected_masks.size() == 0)
            begin
                $error("split_mask: expected nothing, actual %0d", mask_ch.split_mask);
                mask_errors++;
            end
            else
            begin
                exp_mask = expected_masks.pop_front();
                if (mask_ch.split_mask !== exp_mask)
                begin
                    $error("split_mask: expected %0d, actual %0d", exp_mask,
                        mask_ch.split_mask);
                    mask_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencing: reset, directed spheres, then random phases
    // ------------------------------------------------------------------
    initial
    begin
        ssm_cfg_t dcfg;
        int       scale;

        // every input known from time zero
        rst_n                   = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        sphere_ch.valid         = 1'b0;
        sphere_ch.center_x      = '0;
        sphere_ch.center_y      = '0;
        sphere_ch.center_z      = '0;
        sphere_ch.sphere_radius = '0;
        mask_ch.ready           = 1'b0;

        shadow_cfg               = '0;
        shadow_cfg.light_x       = LIGHT_X_RESET;
        shadow_cfg.light_y       = LIGHT_Y_RESET;
        shadow_cfg.light_z       = LIGHT_Z_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset settings: light straight down, every split at zero
        queue_sphere(0, 0, 0, 0);
        queue_sphere(C_MAX, C_MAX, C_MAX, R_MAX);
        queue_sphere(C_MIN, C_MIN, C_MIN, 0);
        wait_drained();

        // ascending splits at 10, 50, 200 and 1000 units, light along -y
        dcfg               = '0;
        dcfg.light_y       = -16'sd16384;
        dcfg.split_dist[0] = 24'd2560;
        dcfg.split_dist[1] = 24'd12800;
        dcfg.split_dist[2] = 24'd51200;
        dcfg.split_dist[3] = 24'd256000;
        apply_config(dcfg);
        write_reg(REG_UNUSED, 24'hA5A5A5);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        queue_sphere(0, 0, 0, 0);
        queue_sphere(0, C_MAX, 0, 0);
        queue_sphere(7680, 0, 0, 0);
        queue_sphere(7680, 0, 0, 1023);
        queue_sphere(7680, 0, 0, 1024);
        queue_sphere(2560, 0, 0, 0);
        queue_sphere(C_MAX, 0, C_MAX, R_MAX);
        queue_sphere(C_MIN, C_MIN, C_MIN, 0);
        queue_sphere(0, 0, 0, R_MAX);
        queue_sphere(0, 0, -5000, 300);
        wait_drained();

        // light far from unit length, splits out of order
        dcfg.light_x       = 16'sd16384;
        dcfg.light_y       = 16'sd16384;
        dcfg.light_z       = 16'sd16384;
        dcfg.split_dist[0] = 24'd51200;
        dcfg.split_dist[1] = 24'd2560;
        dcfg.split_dist[2] = 24'd256000;
        dcfg.split_dist[3] = 24'd12800;
        apply_config(dcfg);
        queue_sphere(1000, -2000, 3000, 50);
        queue_sphere(C_MAX, C_MIN, C_MAX, 1);
        queue_sphere(-20000, 0, 20000, 4000);
        queue_sphere(256, 256, 256, 0);
        wait_drained();

        // most negative light register, largest positive, splits at their top
        dcfg.light_x = 16'sh8000;
        dcfg.light_y = 16'sh7FFF;
        dcfg.light_z = -16'sd16384;
        for (int i = 0; i < MAX_SPLITS; i++)
            dcfg.split_dist[i] = SPLIT_MAX;
        apply_config(dcfg);
        queue_sphere(C_MAX, C_MIN, 256, 0);
        queue_sphere(C_MIN, C_MAX, C_MIN, R_MAX);
        queue_sphere(-1, -1, -1, 1);
        wait_drained();

        // random phases, each under fresh settings and its own idling mix
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            scale      = (ph == 0) ? 0 : $urandom_range(0, 14);
            // the hold-off phase keeps the sender busy so the block fills and stalls
            tx_idle_en = (ph != 2 && ph != 5);
            rx_idle_en = (ph != 5);
            dcfg       = random_config(scale);
            if (ph == RANDOM_PHASES - 1)
            begin
                dcfg.split_dist[0] = '0;
                dcfg.split_dist[1] = '0;
                dcfg.split_dist[2] = SPLIT_MAX;
                dcfg.split_dist[3] = SPLIT_MAX;
            end
            apply_config(dcfg);
            if (ph == 2)
                hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE)
            begin
                pending_spheres.push_back(random_sphere(scale));
                spheres_queued++;
            end
            // sender stops here until every mask of the phase is back
            wait_drained();
        end

        // anything trailing out of the pipeline would show up as unexpected
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mask_errors == 0 && expected_masks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### shadow_split_membership_top.f
rtl/ssm_pkg.sv
rtl/ssm_if.sv
rtl/ssm_proj.sv
rtl/ssm_isqrt.sv
rtl/ssm_select.sv
rtl/shadow_split_membership_top.sv
tb/sv/shadow_split_membership_top_tb.sv
